[design/sfrc_pkg.sv]
package sfrc_pkg;

	// Widths of the stream payloads and of the byte counter.
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 8;
	localparam int SUM_W    = 16;
	localparam int STATUS_W = 2;
	localparam int CMD_W    = 8;
	localparam int HEAD_W   = 32;
	localparam int TAIL_W   = 64;
	localparam int OUT_W    = STATUS_W + CMD_W + HEAD_W + TAIL_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Frame marker bytes.
	localparam logic [BYTE_W-1:0] HEAD0 = 8'h22;
	localparam logic [BYTE_W-1:0] HEAD1 = 8'h33;
	localparam logic [BYTE_W-1:0] TAIL0 = 8'h44;
	localparam logic [BYTE_W-1:0] TAIL1 = 8'h55;

	// Frame status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SHORT     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_HEAD  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_BAD_CHECK = 2'd3;

	// Control shared by every cell of the byte window.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

[design/sfrc_cell.sv]
module sfrc_cell
	import sfrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [BYTE_W-1:0] din,
	output logic [BYTE_W-1:0] dout
);

	logic [BYTE_W-1:0] data_q;

	// One window byte: clear wins over a shift from the neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctrl.clear) begin
			data_q <= '0;
		end else if (ctrl.shift) begin
			data_q <= din;
		end
	end

	assign dout = data_q;

endmodule

[design/serial_frame_receiver_checker_core.sv]
// Serial frame receiver and checker.
//
// The slave stream takes one received byte per transfer. The block keeps the
// last FRAME_LEN bytes in a row of byte cells and counts the bytes since the
// last clear. When the two newest bytes are 0x44 0x55, one result leaves on
// the master stream: a frame status (ok, too short, bad header, bad checksum)
// with the command byte and the payload fields of the frame.
//
// A trailer on a short frame goes straight to the holding state, which loads
// the output register. A trailer on a full frame starts a check: the check
// state captures header and fields, then the window shifts out toward cell 0
// through a single 16-bit adder, one byte per cycle over FRAME_LEN-4 bytes,
// and the holding state loads the result. s_tready stays low during the check.
//
// Reset clears the window, the counter and the output valid. While a result
// waits in the output register, bytes are still taken; a further result waits
// in the holding state, with s_tready low, until m_tready frees the register.
module serial_frame_receiver_checker_core
	import sfrc_pkg::*;
#(
	parameter int unsigned FRAME_LEN   = 20,
	parameter int unsigned COUNT_LIMIT = 255
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,   // rx_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // frame_status, command_byte,
	                                          // payload_head, payload_tail, zero pad
);

	localparam int unsigned SUM_STEPS = FRAME_LEN - 4;
	localparam int STEP_W = $clog2(SUM_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SUM,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [STEP_W-1:0]     step_q;
	logic [SUM_W-1:0]      acc_q;
	logic [SUM_W-1:0]      given_q;
	logic                  head_bad_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [CMD_W-1:0]      res_cmd_q;
	logic [HEAD_W-1:0]     res_head_q;
	logic [TAIL_W-1:0]     res_tail_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [CMD_W-1:0]      out_cmd_q;
	logic [HEAD_W-1:0]     out_head_q;
	logic [TAIL_W-1:0]     out_tail_q;

	logic [BYTE_W-1:0]     win [FRAME_LEN];
	logic [BYTE_W-1:0]     shift_in;
	cell_ctrl_t            ctrl;
	logic                  accept;
	logic [CNT_W-1:0]      count_next;
	logic                  trailer;
	logic                  full_frame;
	logic                  last_step;
	logic [SUM_W-1:0]      acc_next;
	logic                  out_free;
	logic [HEAD_W-1:0]     head_w;
	logic [TAIL_W-1:0]     tail_w;

	// Byte window: cell 0 is the oldest byte, new bytes enter at the top.
	for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
		logic [BYTE_W-1:0] din;
		if (i == FRAME_LEN - 1) begin : g_top
			assign din = shift_in;
		end else begin : g_mid
			assign din = win[i+1];
		end
		sfrc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.din    (din),
			.dout   (win[i])
		);
	end

	// Payload taps; positions past the frame read as zero.
	for (genvar k = 0; k < 4; k++) begin : g_head
		if (3 + k < FRAME_LEN) begin : g_in
			assign head_w[HEAD_W-1-8*k -: 8] = win[3+k];
		end else begin : g_out
			assign head_w[HEAD_W-1-8*k -: 8] = '0;
		end
	end
	for (genvar k = 0; k < 8; k++) begin : g_tail
		if (7 + k < FRAME_LEN) begin : g_in
			assign tail_w[TAIL_W-1-8*k -: 8] = win[7+k];
		end else begin : g_out
			assign tail_w[TAIL_W-1-8*k -: 8] = '0;
		end
	end

	// Handshake and trailer detection on the incoming byte.
	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign count_next = (count_q == {CNT_W{1'b1}}) ? count_q : count_q + CNT_W'(1);
	assign trailer    = (count_next >= CNT_W'(2)) && (win[FRAME_LEN-1] == TAIL0) &&
	                    (s_tdata == TAIL1);
	assign full_frame = (count_next >= CNT_W'(FRAME_LEN));
	assign last_step  = (step_q == STEP_W'(SUM_STEPS - 1));
	assign acc_next   = acc_q + {{(SUM_W-BYTE_W){1'b0}}, win[0]};
	assign out_free   = !out_valid_q || m_tready;

	// Cell control: shift bytes in, drain during the sum, clear on frame end or at the count limit.
	always_comb begin
		ctrl.shift = 1'b0;
		ctrl.clear = 1'b0;
		shift_in   = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					shift_in = s_tdata;
					if (trailer && !full_frame) begin
						ctrl.clear = 1'b1;
					end else if (!trailer && count_next >= CNT_W'(COUNT_LIMIT)) begin
						ctrl.clear = 1'b1;
					end else begin
						ctrl.shift = 1'b1;
					end
				end
			end
			ST_SUM: begin
				if (last_step) begin
					ctrl.clear = 1'b1;
				end else begin
					ctrl.shift = 1'b1;
				end
			end
			default: begin
				ctrl.shift = 1'b0;
			end
		endcase
	end

	// Sequencer, checksum accumulator and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			step_q       <= '0;
			acc_q        <= '0;
			given_q      <= '0;
			head_bad_q   <= 1'b0;
			res_status_q <= '0;
			res_cmd_q    <= '0;
			res_head_q   <= '0;
			res_tail_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_cmd_q    <= '0;
			out_head_q   <= '0;
			out_tail_q   <= '0;
		end else begin
			// The output register is loaded from the holding state and freed
			// by a transfer on the master side.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (trailer) begin
							count_q <= '0;
							if (full_frame) begin
								state_q <= ST_CHECK;
							end else begin
								res_status_q <= STATUS_SHORT;
								res_cmd_q    <= '0;
								res_head_q   <= '0;
								res_tail_q   <= '0;
								state_q      <= ST_DONE;
							end
						end else if (count_next >= CNT_W'(COUNT_LIMIT)) begin
							count_q <= '0;
						end else begin
							count_q <= count_next;
						end
					end
				end
				ST_CHECK: begin
					head_bad_q <= (win[0] != HEAD0) || (win[1] != HEAD1);
					given_q    <= {win[FRAME_LEN-4], win[FRAME_LEN-3]};
					res_cmd_q  <= win[2];
					res_head_q <= head_w;
					res_tail_q <= tail_w;
					acc_q      <= '0;
					step_q     <= '0;
					state_q    <= ST_SUM;
				end
				ST_SUM: begin
					acc_q  <= acc_next;
					step_q <= step_q + STEP_W'(1);
					if (last_step) begin
						if (head_bad_q) begin
							res_status_q <= STATUS_BAD_HEAD;
						end else if (acc_next != given_q) begin
							res_status_q <= STATUS_BAD_CHECK;
						end else begin
							res_status_q <= STATUS_OK;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_cmd_q    <= res_cmd_q;
						out_head_q   <= res_head_q;
						out_tail_q   <= res_tail_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_tail_q, out_head_q, out_cmd_q,
	                   out_status_q};

	// The counter is cleared before it can stay at the limit.
	a_count_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(COUNT_LIMIT))
		else $error("byte count reached the limit without a clear");

	// The sum never runs past the checked part of the frame.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (step_q <= STEP_W'(SUM_STEPS - 1)))
		else $error("checksum step counter out of range");

	// The window is empty once the check has finished.
	a_window_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && $past(state_q) == ST_SUM) |->
		(win[0] == '0 && win[FRAME_LEN-1] == '0 && count_q == '0))
		else $error("window not cleared after frame check");

	// A result only appears when the holding state hands it over.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result loaded outside the holding state");

endmodule

[test/serial_frame_receiver_checker_core_test.sv]
module serial_frame_receiver_checker_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sfrc_pkg::*;

	localparam int unsigned FRAME_LEN   = 20;
	localparam int unsigned COUNT_LIMIT = 255;
	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int MAX_REPORTS  = 10;

	// Bit positions of the result fields inside m_tdata.
	localparam int CMD_LSB  = STATUS_W;
	localparam int HEAD_LSB = CMD_LSB + CMD_W;
	localparam int TAIL_LSB = HEAD_LSB + HEAD_W;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CMD_W-1:0]    command;
		logic [HEAD_W-1:0]   head;
		logic [TAIL_W-1:0]   tail;
	} frame_result_t;

	// One row of the directed stimulus. Where fixed is set, the expectation
	// is the one typed in the row; otherwise the frame model decides it.
	typedef struct packed {
		logic [BYTE_W-1:0] rx;
		logic              fixed;
		logic              has_result;
		frame_result_t     want;
	} directed_row_t;

	localparam frame_result_t NO_RESULT   = '0;
	localparam frame_result_t SHORT_FRAME = '{STATUS_SHORT, 8'h00, 32'h0, 64'h0};
	localparam frame_result_t ALL_ONES_OK =
		'{STATUS_OK, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};

	// Trailer right after reset, a lone trailer byte, then a full frame whose
	// command and payload bytes are all ones.
	directed_row_t directed_rows [24] = '{
		'{8'h44, 1'b1, 1'b0, NO_RESULT},
		'{8'h55, 1'b1, 1'b1, SHORT_FRAME},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h55, 1'b0, 1'b0, NO_RESULT},
		'{8'h22, 1'b0, 1'b0, NO_RESULT},
		'{8'h33, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h0E, 1'b0, 1'b0, NO_RESULT},
		'{8'h47, 1'b0, 1'b0, NO_RESULT},
		'{8'h44, 1'b0, 1'b0, NO_RESULT},
		'{8'h55, 1'b1, 1'b1, ALL_ONES_OK}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata = '0;   // rx_byte
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // frame_status, command_byte,
	                                        // payload_head, payload_tail, zero pad

	// Frame model state.
	logic [BYTE_W-1:0] model_window [FRAME_LEN];
	logic [CNT_W-1:0]  model_count;

	frame_result_t pending_results [$];

	int send_idle_pct  = 0;
	int ready_stall_pct = 0;
	int cycle_count    = 0;
	int bytes_sent     = 0;
	int results_seen   = 0;
	int mismatches     = 0;
	int status_seen [4] = '{0, 0, 0, 0};

	serial_frame_receiver_checker_core #(
		.FRAME_LEN  (FRAME_LEN),
		.COUNT_LIMIT(COUNT_LIMIT)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results still expected.",
				cycle_count, pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// The result side stalls at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= ready_stall_pct);
	end

	function automatic void clear_frame_model();
		foreach (model_window[k]) model_window[k] = '0;
		model_count = '0;
	endfunction

	// A frame position beyond the window reads as zero.
	function automatic logic [BYTE_W-1:0] window_byte(int unsigned pos);
		if (pos >= FRAME_LEN) return '0;
		return model_window[pos];
	endfunction

	// Shift one byte into the model and report the frame result it causes.
	task automatic receive_into_model(input logic [BYTE_W-1:0] rx, output bit produced,
		output frame_result_t res);
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] given;
		produced = 1'b0;
		res = '0;
		if (model_count >= COUNT_LIMIT) clear_frame_model();
		for (int k = 0; k < FRAME_LEN - 1; k++) model_window[k] = model_window[k + 1];
		model_window[FRAME_LEN - 1] = rx;
		if (model_count != 8'hFF) model_count = model_count + CNT_W'(1);

		if (model_count >= 2 && model_window[FRAME_LEN - 2] == TAIL0 &&
				model_window[FRAME_LEN - 1] == TAIL1) begin
			produced = 1'b1;
			if (model_count >= FRAME_LEN) begin
				sum = '0;
				for (int k = 0; k + 4 < FRAME_LEN; k++)
					sum = sum + SUM_W'(model_window[k]);
				given = {model_window[FRAME_LEN - 4], model_window[FRAME_LEN - 3]};
				if (model_window[0] != HEAD0 || model_window[1] != HEAD1)
					res.status = STATUS_BAD_HEAD;
				else if (sum != given)
					res.status = STATUS_BAD_CHECK;
				else
					res.status = STATUS_OK;
				res.command = window_byte(2);
				for (int k = 0; k < 4; k++) res.head = {res.head[HEAD_W-9:0], window_byte(3 + k)};
				for (int k = 0; k < 8; k++) res.tail = {res.tail[TAIL_W-9:0], window_byte(7 + k)};
			end else begin
				res.status = STATUS_SHORT;
			end
			clear_frame_model();
		end
		if (model_count >= COUNT_LIMIT) clear_frame_model();
	endtask

	// Offer one byte, idling first at the rate of the phase, and record what it
	// should cause once the transfer happens.
	task automatic send_byte(input logic [BYTE_W-1:0] rx, input bit fixed = 1'b0,
		input bit fixed_has = 1'b0, input frame_result_t fixed_want = '0);
		bit produced;
		frame_result_t res;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		do @(posedge clk); while (!s_tready);
		receive_into_model(rx, produced, res);
		if (fixed) begin
			produced = fixed_has;
			res = fixed_want;
		end
		if (produced) pending_results.push_back(res);
		bytes_sent++;
	endtask

	// Random byte that never completes a trailer after the previous one.
	function automatic logic [BYTE_W-1:0] body_byte(logic [BYTE_W-1:0] prev);
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom_range(255));
		if (prev == TAIL0 && b == TAIL1) b = 8'h56;
		return b;
	endfunction

	// Noise with many marker bytes, so that stray trailers turn up.
	function automatic logic [BYTE_W-1:0] noise_byte();
		case ($urandom_range(3))
			0: return TAIL0;
			1: return TAIL1;
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	// Build and send one random sequence: mostly well-formed frames, some with
	// a broken header or checksum, short frames, noise, and long runs that can
	// push the byte counter to its limit.
	task automatic send_random_sequence();
		logic [BYTE_W-1:0] frame [$];
		logic [SUM_W-1:0]  sum;
		logic [BYTE_W-1:0] prev;
		int kind;
		int n;
		kind = $urandom_range(99);
		prev = '0;
		sum = '0;

		if (kind >= 97) begin
			n = $urandom_range(270, 200);
			for (int k = 0; k < n; k++) begin
				prev = body_byte(prev);
				frame.push_back(prev);
			end
		end else if ($urandom_range(4) == 0) begin
			n = $urandom_range(10, 1);
			for (int k = 0; k < n; k++) frame.push_back(noise_byte());
		end

		if (kind < 75 || kind >= 97) begin
			// Full frame: header, command and payload, checksum, trailer.
			frame.push_back(HEAD0);
			frame.push_back(HEAD1);
			prev = HEAD1;
			sum = SUM_W'(HEAD0) + SUM_W'(HEAD1);
			for (int k = 2; k < FRAME_LEN - 4; k++) begin
				prev = body_byte(prev);
				frame.push_back(prev);
				sum = sum + SUM_W'(prev);
			end
			frame.push_back(sum[15:8]);
			frame.push_back(sum[7:0]);
			frame.push_back(TAIL0);
			frame.push_back(TAIL1);
			n = frame.size() - FRAME_LEN;
			if (kind >= 55 && kind < 65)
				frame[n + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
			else if (kind >= 65 && kind < 75)
				frame[n + FRAME_LEN - 4 + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
		end else if (kind < 87) begin
			n = $urandom_range(FRAME_LEN - 3);
			for (int k = 0; k < n; k++) begin
				prev = body_byte(prev);
				frame.push_back(prev);
			end
			frame.push_back(TAIL0);
			frame.push_back(TAIL1);
		end else begin
			n = $urandom_range(30, 1);
			for (int k = 0; k < n; k++) frame.push_back(noise_byte());
		end

		foreach (frame[k]) send_byte(frame[k]);
	endtask

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status  = m_tdata[CMD_LSB-1:0];
			got.command = m_tdata[HEAD_LSB-1:CMD_LSB];
			got.head    = m_tdata[TAIL_LSB-1:HEAD_LSB];
			got.tail    = m_tdata[TAIL_LSB+TAIL_W-1:TAIL_LSB];
			results_seen++;
			status_seen[got.status]++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Unexpected result: status %0d command %h head %h tail %h",
						got.status, got.command, got.head, got.tail);
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status || got.command != want.command ||
						got.head != want.head || got.tail != want.tail) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("Result %0d mismatch:", results_seen);
						$display("  expected status %0d command %h head %h tail %h",
							want.status, want.command, want.head, want.tail);
						$display("  actual   status %0d command %h head %h tail %h",
							got.status, got.command, got.head, got.tail);
					end
				end
			end
		end
	end

	// Reset, directed rows, random sequences in four pacing phases, then drain.
	initial begin
		int random_start;
		int phase;
		clear_frame_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_byte(directed_rows[k].rx, directed_rows[k].fixed,
				directed_rows[k].has_result, directed_rows[k].want);

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_ITEMS) begin
			phase = (bytes_sent - random_start) * 4 / RANDOM_ITEMS;
			case (phase)
				0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
				1: begin send_idle_pct = 60; ready_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  ready_stall_pct = 60; end
				default: begin send_idle_pct = 29; ready_stall_pct = 29; end
			endcase
			send_random_sequence();
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * FRAME_LEN) @(posedge clk);
		mismatches += pending_results.size();

		$display("Sent %0d bytes and checked %0d frame results under four pacing phases.",
			bytes_sent, results_seen);
		$display("Status mix: ok %0d, too short %0d, bad header %0d, bad checksum %0d.",
			status_seen[STATUS_OK], status_seen[STATUS_SHORT],
			status_seen[STATUS_BAD_HEAD], status_seen[STATUS_BAD_CHECK]);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches.", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[files.f]
design/sfrc_pkg.sv
design/sfrc_cell.sv
design/serial_frame_receiver_checker_core.sv
test/serial_frame_receiver_checker_core_test.sv
